### rtl/core/vn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package vn_pkg;
    // component and result widths
    localparam int CompW  = 16;
    localparam int Lanes  = 3;
    // quotient bits searched per lane, one pipeline stage each
    localparam int QBits  = 15;
    // squared magnitude, sum of squares, scaled numerator
    localparam int SqW    = 31;
    localparam int SumW   = 32;
    localparam int NumW   = SqW + 28;
    // running q*q*S and q*S
    localparam int AccW   = 63;
    localparam int ProdW  = 47;
    localparam logic [CompW-1:0] UnitOne = 16'd16384;

    // control that rides alongside the data
    typedef struct packed {
        logic valid;
        logic zero;
    } vn_ctrl_t;
endpackage
`default_nettype wire

### rtl/core/vector3_normalize.sv
`timescale 1ns / 1ps
`default_nettype none
// Pipeline: 2 square/sum stages, 15 root-divide stages per lane, 1 output register,
// passed in that order from request accept to result valid.
// Throughput: one vector per cycle; the whole pipeline advances when the
// output register is empty or being taken.
// Reset: aresetn synchronous, clears all valid bits; data is not reset.
module vector3_normalize (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // vec_x[15:0], vec_y[31:16], vec_z[47:32]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // unit_x[15:0], unit_y[31:16], unit_z[47:32]
    output logic             m_tuser    // zero_vector[0]
);
    import vn_pkg::*;

    localparam int Depth = 2 + QBits;

    logic                           ce;
    vn_ctrl_t                       ctrl_reg [0:Depth-1];
    logic [Lanes-1:0][CompW-1:0]    comp;
    logic [Lanes-1:0][SqW-1:0]      mag_sq;
    logic [Lanes-1:0]               neg;
    logic [SumW-1:0]                sum;
    logic                           zero;
    logic [Lanes-1:0][QBits-1:0]    q;
    logic [Lanes-1:0]               q_neg;

    assign ce       = !m_tvalid || m_tready;
    assign s_tready = ce;

    for (genvar i = 0; i < Lanes; i++) begin : g_split
        assign comp[i] = s_tdata[i*CompW +: CompW];
    end

    // advance request tags alongside the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < Depth; i++) begin
                ctrl_reg[i] <= '0;
            end
        end else if (ce) begin
            ctrl_reg[0] <= '{valid: s_tvalid, zero: 1'b0};
            ctrl_reg[1] <= '{valid: ctrl_reg[0].valid, zero: 1'b0};
            ctrl_reg[2] <= '{valid: ctrl_reg[1].valid, zero: zero};
            for (int i = 3; i < Depth; i++) begin
                ctrl_reg[i] <= ctrl_reg[i-1];
            end
        end
    end

    vn_front u_front (
        .aclk   (aclk),
        .ce     (ce),
        .comp   (comp),
        .mag_sq (mag_sq),
        .neg    (neg),
        .sum    (sum),
        .zero   (zero)
    );

    for (genvar i = 0; i < Lanes; i++) begin : g_lane
        vn_lane u_lane (
            .aclk   (aclk),
            .ce     (ce),
            .mag_sq (mag_sq[i]),
            .sum    (sum),
            .neg    (neg[i]),
            .q      (q[i]),
            .q_neg  (q_neg[i])
        );
    end

    vn_merge u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ce       (ce),
        .ctrl     (ctrl_reg[Depth-1]),
        .q        (q),
        .q_neg    (q_neg),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // a null vector gives all-zero components
    a_zero_data : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("zero vector with nonzero components");

    // every component stays within plus or minus one
    a_range : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[15:0]) <= 16384 && $signed(m_tdata[15:0]) >= -16384
                   && $signed(m_tdata[31:16]) <= 16384 && $signed(m_tdata[31:16]) >= -16384
                   && $signed(m_tdata[47:32]) <= 16384 && $signed(m_tdata[47:32]) >= -16384))
        else $error("unit component out of range");

    // a request leaving the last lane stage lands in the output register
    a_deliver : assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl_reg[Depth-1].valid && ce) |=> m_tvalid)
        else $error("request lost at output");
endmodule
`default_nettype wire

### rtl/core/vn_front.sv
`timescale 1ns / 1ps
`default_nettype none
module vn_front (
    input  wire logic                                   aclk,
    input  wire logic                                   ce,
    input  wire logic [vn_pkg::Lanes-1:0][vn_pkg::CompW-1:0] comp,
    output logic [vn_pkg::Lanes-1:0][vn_pkg::SqW-1:0]   mag_sq,
    output logic [vn_pkg::Lanes-1:0]                    neg,
    output logic [vn_pkg::SumW-1:0]                     sum,
    output logic                                        zero
);
    import vn_pkg::*;

    logic [Lanes-1:0][SqW-1:0]   sq1_reg;
    logic [Lanes-1:0]            neg1_reg;
    logic [Lanes-1:0][SqW-1:0]   sq2_reg;
    logic [Lanes-1:0]            neg2_reg;
    logic [SumW-1:0]             sum_reg;
    logic                        zero_reg;
    logic [Lanes-1:0][SqW-1:0]   sq_next;
    logic [SumW-1:0]             sum_next;

    // square each component magnitude
    always_comb begin
        logic [CompW-1:0]   mag;
        logic [2*CompW-1:0] prod;
        for (int i = 0; i < Lanes; i++) begin
            mag        = comp[i][CompW-1] ? (~comp[i] + 1'b1) : comp[i];
            prod       = mag * mag;
            sq_next[i] = prod[SqW-1:0];
        end
    end

    assign sum_next = {1'b0, sq1_reg[0]} + {1'b0, sq1_reg[1]} + {1'b0, sq1_reg[2]};

    // advance the two front stages
    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int i = 0; i < Lanes; i++) begin
                neg1_reg[i] <= comp[i][CompW-1];
            end
            sq1_reg  <= sq_next;
            sq2_reg  <= sq1_reg;
            neg2_reg <= neg1_reg;
            sum_reg  <= sum_next;
            zero_reg <= (sum_next == '0);
        end
    end

    assign mag_sq = sq2_reg;
    assign neg    = neg2_reg;
    assign sum    = sum_reg;
    assign zero   = zero_reg;
endmodule
`default_nettype wire

### rtl/core/vn_lane.sv
`timescale 1ns / 1ps
`default_nettype none
module vn_lane (
    input  wire logic                      aclk,
    input  wire logic                      ce,
    input  wire logic [vn_pkg::SqW-1:0]    mag_sq,
    input  wire logic [vn_pkg::SumW-1:0]   sum,
    input  wire logic                      neg,
    output logic [vn_pkg::QBits-1:0]       q,
    output logic                           q_neg
);
    import vn_pkg::*;

    // stage k holds the search state before bit QBits-1-k is decided
    logic [AccW-1:0]  a_reg   [1:QBits];
    logic [ProdW-1:0] b_reg   [1:QBits];
    logic [QBits-1:0] q_reg   [1:QBits];
    logic [NumW-1:0]  n_reg   [1:QBits];
    logic [SumW-1:0]  s_reg   [1:QBits];
    logic             neg_reg [1:QBits];

    for (genvar k = 0; k < QBits; k++) begin : g_stage
        localparam int B = QBits - 1 - k;
        logic [AccW-1:0]  cur_a;
        logic [ProdW-1:0] cur_b;
        logic [QBits-1:0] cur_q;
        logic [NumW-1:0]  cur_n;
        logic [SumW-1:0]  cur_s;
        logic             cur_neg;
        logic [AccW-1:0]  trial;
        logic             take;

        if (k == 0) begin : g_first
            assign cur_a   = '0;
            assign cur_b   = '0;
            assign cur_q   = '0;
            assign cur_n   = {mag_sq, 28'd0};
            assign cur_s   = sum;
            assign cur_neg = neg;
        end else begin : g_rest
            assign cur_a   = a_reg[k];
            assign cur_b   = b_reg[k];
            assign cur_q   = q_reg[k];
            assign cur_n   = n_reg[k];
            assign cur_s   = s_reg[k];
            assign cur_neg = neg_reg[k];
        end

        // (q + 2^B)^2 * S = q^2*S + 2^(B+1)*q*S + 2^(2B)*S
        assign trial = cur_a
                     + (AccW'(cur_b) << (B + 1))
                     + (AccW'(cur_s) << (2 * B));
        assign take  = (trial <= AccW'(cur_n));

        // keep the bit when the trial square stays at or under the numerator
        always_ff @(posedge aclk) begin
            if (ce) begin
                a_reg[k+1]   <= take ? trial : cur_a;
                b_reg[k+1]   <= take ? (cur_b + (ProdW'(cur_s) << B)) : cur_b;
                q_reg[k+1]   <= take ? (cur_q | (QBits'(1) << B)) : cur_q;
                n_reg[k+1]   <= cur_n;
                s_reg[k+1]   <= cur_s;
                neg_reg[k+1] <= cur_neg;
            end
        end
    end

    assign q     = q_reg[QBits];
    assign q_neg = neg_reg[QBits];
endmodule
`default_nettype wire

### rtl/core/vn_merge.sv
`timescale 1ns / 1ps
`default_nettype none
module vn_merge (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   ce,
    input  wire vn_pkg::vn_ctrl_t                       ctrl,
    input  wire logic [vn_pkg::Lanes-1:0][vn_pkg::QBits-1:0] q,
    input  wire logic [vn_pkg::Lanes-1:0]               q_neg,
    output logic                                        m_tvalid,
    output logic [vn_pkg::Lanes*vn_pkg::CompW-1:0]      m_tdata,
    output logic                                        m_tuser
);
    import vn_pkg::*;

    logic                          valid_reg;
    logic [Lanes*CompW-1:0]        data_reg;
    logic                          zero_reg;
    logic [Lanes*CompW-1:0]        data_next;

    // clamp to one, apply sign, force zero for a null vector
    always_comb begin
        logic [CompW-1:0] mag;
        for (int i = 0; i < Lanes; i++) begin
            mag = {1'b0, q[i]};
            if (mag > UnitOne) begin
                mag = UnitOne;
            end
            if (ctrl.zero) begin
                mag = '0;
            end
            data_next[i*CompW +: CompW] = q_neg[i] ? (~mag + 1'b1) : mag;
        end
    end

    // hold the result until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ce) begin
            valid_reg <= ctrl.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            data_reg <= data_next;
            zero_reg <= ctrl.zero;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = zero_reg;
endmodule
`default_nettype wire

### verif/vector3_normalize_tb.sv
`timescale 1ns / 1ps
module vector3_normalize_tb;
    import vn_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic        m_tuser;

    typedef struct packed {
        logic [CompW-1:0] ux;
        logic [CompW-1:0] uy;
        logic [CompW-1:0] uz;
        logic             zero;
    } unit_vec_t;

    // directed row: vector, and a typed-in result where it is obvious
    typedef struct packed {
        logic [CompW-1:0] vx;
        logic [CompW-1:0] vy;
        logic [CompW-1:0] vz;
        logic             known;
        unit_vec_t        res;
    } vec_row_t;

    localparam int NumDirected = 20;
    localparam int NumRandom   = 1930;
    localparam logic [CompW-1:0] NegOne = 16'hC000;

    unit_vec_t unit_q[$];
    int        n_fail;
    int        n_sent;
    int        n_seen;
    int        n_zero;
    bit        send_done;
    vec_row_t  dir_rows [NumDirected];

    vector3_normalize dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end

    // truncated |c| * 2^14 / sqrt(sum), clamped to 2^14, sign of c applied
    function automatic logic [CompW-1:0] unit_of(logic signed [CompW-1:0] c,
                                                 logic [63:0] sum);
        logic [63:0]  mag;
        logic [127:0] num;
        logic [127:0] t;
        logic [63:0]  q;
        mag = (c < 0) ? 64'(-int'(c)) : 64'(int'(c));
        num = 128'(mag * mag) << 28;
        q = 0;
        for (int b = 14; b >= 0; b--) begin
            t = 128'(q | (64'd1 << b));
            if (t * t * sum <= num)
                q = q | (64'd1 << b);
        end
        if (q > 64'd16384)
            q = 64'd16384;
        if (c < 0)
            q = -q;
        return q[CompW-1:0];
    endfunction

    function automatic unit_vec_t normalize(logic [CompW-1:0] vx, logic [CompW-1:0] vy,
                                            logic [CompW-1:0] vz);
        unit_vec_t r;
        logic [63:0] sum;
        sum = 64'(int'($signed(vx)) * int'($signed(vx)))
            + 64'(int'($signed(vy)) * int'($signed(vy)))
            + 64'(int'($signed(vz)) * int'($signed(vz)));
        if (sum == 0) begin
            r = '{0, 0, 0, 1'b1};
        end else begin
            r.ux = unit_of(vx, sum);
            r.uy = unit_of(vy, sum);
            r.uz = unit_of(vz, sum);
            r.zero = 1'b0;
        end
        return r;
    endfunction

    // offer one request, with a random gap first
    task automatic send_vec(vec_row_t row);
        int gap;
        gap = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {row.vz, row.vy, row.vx};
        unit_q.push_back(row.known ? row.res : normalize(row.vx, row.vy, row.vz));
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        n_sent++;
    endtask

    function automatic logic [CompW-1:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return CompW'($urandom_range(0, 15)) - 16'd8;
            default: return CompW'($urandom);
        endcase
    endfunction

    // stimulus: directed table, then random vectors
    initial begin
        vec_row_t row;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        aresetn   = 1'b0;
        n_fail    = 0;
        n_sent    = 0;
        send_done = 0;
        dir_rows[0]  = '{16'h0000, 16'h0000, 16'h0000, 1'b1, '{0, 0, 0, 1'b1}};
        dir_rows[1]  = '{16'h0100, 16'h0000, 16'h0000, 1'b1, '{UnitOne, 0, 0, 1'b0}};
        dir_rows[2]  = '{16'h0000, 16'h0001, 16'h0000, 1'b1, '{0, UnitOne, 0, 1'b0}};
        dir_rows[3]  = '{16'h0000, 16'h0000, 16'h7FFF, 1'b1, '{0, 0, UnitOne, 1'b0}};
        dir_rows[4]  = '{16'h8000, 16'h0000, 16'h0000, 1'b1, '{NegOne, 0, 0, 1'b0}};
        dir_rows[5]  = '{16'h0000, 16'h8000, 16'h0000, 1'b1, '{0, NegOne, 0, 1'b0}};
        dir_rows[6]  = '{16'h0000, 16'h0000, 16'hFFFF, 1'b1, '{0, 0, NegOne, 1'b0}};
        dir_rows[7]  = '{16'h8000, 16'h8000, 16'h8000, 1'b0, '0};
        dir_rows[8]  = '{16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, '0};
        dir_rows[9]  = '{16'h7FFF, 16'h8000, 16'h7FFF, 1'b0, '0};
        dir_rows[10] = '{16'h0001, 16'h0001, 16'h0001, 1'b0, '0};
        dir_rows[11] = '{16'hFFFF, 16'h0001, 16'hFFFF, 1'b0, '0};
        dir_rows[12] = '{16'h0003, 16'h0004, 16'h0000, 1'b0, '0};
        dir_rows[13] = '{16'h0001, 16'h8000, 16'h0000, 1'b0, '0};
        dir_rows[14] = '{16'h5555, 16'hAAAA, 16'h1234, 1'b0, '0};
        dir_rows[15] = '{16'h0000, 16'h0000, 16'h0000, 1'b1, '{0, 0, 0, 1'b1}};
        dir_rows[16] = '{16'h0002, 16'h0000, 16'h0002, 1'b0, '0};
        dir_rows[17] = '{16'h8000, 16'h7FFF, 16'h0000, 1'b0, '0};
        dir_rows[18] = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, '0};
        dir_rows[19] = '{16'h0100, 16'hFF00, 16'h0080, 1'b0, '0};
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (dir_rows[i])
            send_vec(dir_rows[i]);
        for (int i = 0; i < NumRandom; i++) begin
            row = '0;
            row.vx = rand_comp();
            row.vy = rand_comp();
            row.vz = rand_comp();
            send_vec(row);
        end
        s_tvalid <= 1'b0;
        send_done = 1;
    end

    // receiver: random stalls, one long hold-off to back the pipe up
    initial begin
        int stall;
        bit held;
        m_tready = 1'b0;
        held     = 0;
        wait (aresetn);
        forever begin
            if (!held && n_seen >= 100) begin
                held = 1;
                m_tready <= 1'b0;
                repeat (60) @(posedge aclk);
            end
            stall = $urandom_range(0, 6);
            if ((n_seen / 200) % 2 == 1)
                stall = 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
        end
    end

    // compare each result with the oldest expectation
    initial begin
        unit_vec_t want;
        unit_vec_t got;
        n_seen = 0;
        n_zero = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                got = '{m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tuser};
                n_seen++;
                if (unit_q.size() == 0) begin
                    $display("%0t: unexpected result exp none got %h", $time, got);
                    n_fail++;
                end else begin
                    want = unit_q.pop_front();
                    if (got.zero) n_zero++;
                    if (got.ux !== want.ux) begin
                        $display("%0t: unit_x exp %h got %h", $time, want.ux, got.ux);
                        n_fail++;
                    end
                    if (got.uy !== want.uy) begin
                        $display("%0t: unit_y exp %h got %h", $time, want.uy, got.uy);
                        n_fail++;
                    end
                    if (got.uz !== want.uz) begin
                        $display("%0t: unit_z exp %h got %h", $time, want.uz, got.uz);
                        n_fail++;
                    end
                    if (got.zero !== want.zero) begin
                        $display("%0t: zero_vector exp %b got %b", $time, want.zero,
                                 got.zero);
                        n_fail++;
                    end
                end
            end
        end
    end

    // drain, settle, report
    initial begin
        wait (send_done);
        while (unit_q.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        $display("Covered %0d vectors, %0d results, %0d zero vectors, one long stall.",
                 n_sent, n_seen, n_zero);
        if (n_fail == 0 && unit_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
